>>> rtl/core/ceaf_pkg.sv
// ceaf_pkg: shared types, register indexes and arithmetic helpers of the
// 3x3 convolution edge filter; no dependencies
package ceaf_pkg;

    localparam int KERNEL_SIZE = 3;
    localparam int PIX_W       = 8;
    localparam int PROD_W      = 17;
    localparam int SUM_W       = 21;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int SIZE_CFG_W  = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_TOP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MIDDLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_BOTTOM = 3'd4;

    localparam logic [CFG_DATA_W-1:0] KERNEL_TOP_RESET    = 24'hFFFEFF;
    localparam logic [CFG_DATA_W-1:0] KERNEL_MIDDLE_RESET = 24'h000000;
    localparam logic [CFG_DATA_W-1:0] KERNEL_BOTTOM_RESET = 24'h010201;

    typedef logic [PIX_W-1:0] pix_t;

    // [row][column], row 0 is the oldest row, column 0 the oldest column
    typedef logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][PIX_W-1:0] win_t;
    // [m][n] signed coefficients, n = 0 in the low byte of a row
    typedef logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][PIX_W-1:0] kern_t;

    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    // position flags of one input word, worked out at acceptance
    typedef struct packed {
        logic row_ge1;
        logic row_ge2;
        logic col_zero;
        logic col_last;
        logic row_is_h;
    } scan_t;

    // which results one input word produces
    typedef struct packed {
        logic emit_main;
        logic emit_edge;
        logic frame_end;
    } emit_t;

    typedef struct packed {
        logic frame_end;
        logic saturated;
        pix_t edge_value;
    } result_t;

    // signed coefficient times unsigned pixel, exact in 17 bits
    function automatic prod_t coef_mul(input logic [PIX_W-1:0] c, input pix_t p);
        logic signed [PROD_W-1:0] a;
        logic signed [PROD_W-1:0] b;
        begin
            a = {{(PROD_W-PIX_W){c[PIX_W-1]}}, c};
            b = {{(PROD_W-PIX_W){1'b0}}, p};
            return a * b;
        end
    endfunction

    function automatic sum_t sext_prod(input prod_t p);
        return {{(SUM_W-PROD_W){p[PROD_W-1]}}, p};
    endfunction

    // |s| saturated at 255
    function automatic result_t make_result(input sum_t s, input logic fend);
        logic [SUM_W-1:0] mag;
        result_t r;
        begin
            mag = s[SUM_W-1] ? (SUM_W'(0) - s) : s;
            r.saturated  = |mag[SUM_W-1:PIX_W];
            r.edge_value = r.saturated ? {PIX_W{1'b1}} : mag[PIX_W-1:0];
            r.frame_end  = fend;
            return r;
        end
    endfunction

endpackage

>>> rtl/core/ceaf_ram.sv
// ceaf_ram: generic simple dual-port ram, one write and one registered read
// port; no dependencies
module ceaf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/core/ceaf_window.sv
// ceaf_window: 3x3 window register, shifted once per input word
// depends on ceaf_pkg
module ceaf_window
    import ceaf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  clear,
    input  logic  in_valid,
    output logic  in_ready,
    input  pix_t  in_pix,
    input  scan_t in_scan,
    input  pix_t  older_pix,
    input  pix_t  newer_pix,
    output logic  out_valid,
    input  logic  out_ready,
    output win_t  win,
    output emit_t emit
);

    win_t  win_reg;
    win_t  win_next;
    emit_t emit_reg;
    emit_t emit_next;
    logic  valid_reg;
    logic  take;

    assign in_ready  = !valid_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign win       = win_reg;
    assign emit      = emit_reg;

    always_comb
    begin
        win_next = win_reg;
        for (int k = 0; k < KERNEL_SIZE; k++)
        begin
            if (in_scan.col_zero)
            begin
                win_next[k][0] = '0;
                win_next[k][1] = '0;
            end
            else
            begin
                win_next[k][0] = win_reg[k][1];
                win_next[k][1] = win_reg[k][2];
            end
        end
        win_next[0][2] = in_scan.row_ge2 ? older_pix : '0;
        win_next[1][2] = in_scan.row_ge1 ? newer_pix : '0;
        win_next[2][2] = in_pix;

        emit_next.emit_main = in_scan.row_ge1 && !in_scan.col_zero;
        emit_next.emit_edge = in_scan.row_ge1 && in_scan.col_last;
        emit_next.frame_end = in_scan.row_is_h;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg   <= '0;
            valid_reg <= 1'b0;
            emit_reg  <= '0;
        end
        else if (clear)
        begin
            win_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            win_reg   <= win_next;
            emit_reg  <= emit_next;
            // words that produce no result drop out here
            valid_reg <= emit_next.emit_main || emit_next.emit_edge;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

endmodule

>>> rtl/core/ceaf_mac.sv
// ceaf_mac: product stage and sum / magnitude stage for the interior result
// and the row-end result; depends on ceaf_pkg
module ceaf_mac
    import ceaf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  win_t    win,
    input  emit_t   emit,
    input  kern_t   kernel,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t main_res,
    output result_t edge_res,
    output emit_t   out_emit
);

    localparam int EDGE_TERMS = 2;

    prod_t   pm_reg [KERNEL_SIZE][KERNEL_SIZE];
    prod_t   pe_reg [KERNEL_SIZE][EDGE_TERMS];
    emit_t   e3_reg;
    logic    v3_reg;
    logic    r3;

    result_t main_reg;
    result_t edge_reg;
    emit_t   e4_reg;
    logic    v4_reg;
    sum_t    sum_main;
    sum_t    sum_edge;

    assign out_valid = v4_reg;
    assign main_res  = main_reg;
    assign edge_res  = edge_reg;
    assign out_emit  = e4_reg;

    assign r3       = !v4_reg || out_ready;
    assign in_ready = !v3_reg || r3;

    // products: flipped kernel, coefficient (m,n) meets window (2-m,2-n);
    // row-end result sees the window shifted left with a zero column
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            for (int m = 0; m < KERNEL_SIZE; m++)
            begin
                for (int n = 0; n < KERNEL_SIZE; n++)
                begin
                    pm_reg[m][n] <= coef_mul(kernel[m][n], win[2-m][2-n]);
                end
                pe_reg[m][0] <= coef_mul(kernel[m][1], win[2-m][2]);
                pe_reg[m][1] <= coef_mul(kernel[m][2], win[2-m][1]);
            end
            e3_reg <= emit;
        end
    end

    always_comb
    begin
        sum_main = '0;
        sum_edge = '0;
        for (int m = 0; m < KERNEL_SIZE; m++)
        begin
            for (int n = 0; n < KERNEL_SIZE; n++)
            begin
                sum_main = sum_main + sext_prod(pm_reg[m][n]);
            end
            for (int j = 0; j < EDGE_TERMS; j++)
            begin
                sum_edge = sum_edge + sext_prod(pe_reg[m][j]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (v3_reg && r3)
        begin
            main_reg <= make_result(sum_main, 1'b0);
            edge_reg <= make_result(sum_edge, e3_reg.frame_end);
            e4_reg   <= e3_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                v3_reg <= in_valid;
            end
            if (r3)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

endmodule

>>> rtl/core/ceaf_out.sv
// ceaf_out: output register holding up to two results of one input word,
// sent one word at a time; depends on ceaf_pkg
module ceaf_out
    import ceaf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t main_res,
    input  result_t edge_res,
    input  emit_t   emit,
    output logic    m_tvalid,
    input  logic    m_tready,
    output logic    m_tlast,
    output result_t m_res
);

    result_t main_reg;
    result_t edge_reg;
    emit_t   emit_reg;
    logic    valid_reg;
    logic    main_sent_reg;
    logic    cur_is_edge;
    logic    final_word;

    assign cur_is_edge = !emit_reg.emit_main || main_sent_reg;
    assign final_word  = cur_is_edge || !emit_reg.emit_edge;
    assign in_ready    = !valid_reg || (m_tready && final_word);
    assign m_tvalid    = valid_reg;
    assign m_tlast     = final_word;
    assign m_res       = cur_is_edge ? edge_reg : main_reg;

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            main_reg <= main_res;
            edge_reg <= edge_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            main_sent_reg <= 1'b0;
            emit_reg      <= '0;
        end
        else if (in_ready)
        begin
            valid_reg     <= in_valid;
            main_sent_reg <= 1'b0;
            if (in_valid)
            begin
                emit_reg <= emit;
            end
        end
        else if (m_tready)
        begin
            // first of two words went out
            main_sent_reg <= 1'b1;
        end
    end

endmodule

>>> rtl/core/conv3x3_abs_edge_filter_top.sv
// conv3x3_abs_edge_filter_top: streaming 3x3 convolution edge filter
// depends on ceaf_pkg, ceaf_ram, ceaf_window, ceaf_mac, ceaf_out
//
//   channel   dir  handshake            payload
//   s_*       in   s_tvalid/s_tready    s_tdata = pixel, s_tuser = opcode
//   m_*       out  m_tvalid/m_tready    m_tdata = edge_value,
//                                       m_tuser = saturated, frame_end; m_tlast
//   cfg_*     in   cfg_we               cfg_index, cfg_wdata
//
// one input word per clock while m_tready is high; the output port then moves one
// word per clock, and a row end's two results fit since the next word yields none
// an input word reaches its first result through the line ram read, window,
// products, sum and magnitude and output register stages, each one registered
// the line buffers need no clearing: entries are used only after being written
// in the same frame; reset and size writes restart the frame
// stalls on m_tready back up stage by stage; empty stages keep taking words
module conv3x3_abs_edge_filter_top
    import ceaf_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,    // [7:0] pixel
    input  logic [0:0]            s_tuser,    // [0] opcode (1 = flush tick)
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,    // [7:0] edge_value
    output logic [1:0]            m_tuser,    // [0] saturated, [1] frame_end
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
    localparam int WEFF_W = $clog2(MAX_WIDTH + 1);
    localparam int WEXT_W = (WEFF_W > SIZE_CFG_W) ? WEFF_W : SIZE_CFG_W;
    localparam int HEXT_W = (ROW_W > SIZE_CFG_W) ? ROW_W : SIZE_CFG_W;
    localparam int LINE_W = 2 * PIX_W;

    // configuration registers
    logic [SIZE_CFG_W-1:0] width_reg;
    logic [SIZE_CFG_W-1:0] height_reg;
    kern_t                 kernel_reg;
    logic                  restart;

    // scan position of the next input word
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [WEXT_W-1:0] width_ext;
    logic [HEXT_W-1:0] height_ext;
    logic [WEFF_W-1:0] width_eff;
    logic [ROW_W-1:0]  height_eff;
    logic [COL_W-1:0]  last_col;
    logic              s_accept;
    scan_t             scan;
    pix_t              pix_in;

    // input register, line ram read in flight
    logic              s1_valid_reg;
    pix_t              s1_pix_reg;
    logic [COL_W-1:0]  s1_col_reg;
    scan_t             s1_scan_reg;
    logic              s1_ready;
    logic              win_ready;
    logic [LINE_W-1:0] line_rdata;
    logic [LINE_W-1:0] line_wdata;
    logic              line_we;

    // stage links
    logic    win_valid;
    win_t    win;
    emit_t   win_emit;
    logic    mac_ready;
    logic    mac_valid;
    result_t mac_main;
    result_t mac_edge;
    emit_t   mac_emit;
    logic    out_ready;
    result_t m_res;

    assign restart = cfg_we
        && (cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= SIZE_CFG_W'(256);
            height_reg    <= SIZE_CFG_W'(256);
            kernel_reg[0] <= KERNEL_TOP_RESET;
            kernel_reg[1] <= KERNEL_MIDDLE_RESET;
            kernel_reg[2] <= KERNEL_BOTTOM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:   width_reg     <= cfg_wdata[SIZE_CFG_W-1:0];
                CFG_IMAGE_HEIGHT:  height_reg    <= cfg_wdata[SIZE_CFG_W-1:0];
                CFG_KERNEL_TOP:    kernel_reg[0] <= cfg_wdata;
                CFG_KERNEL_MIDDLE: kernel_reg[1] <= cfg_wdata;
                CFG_KERNEL_BOTTOM: kernel_reg[2] <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    // sizes in use, clamped into the legal range
    always_comb
    begin
        width_ext  = WEXT_W'(width_reg);
        height_ext = HEXT_W'(height_reg);
        if (width_ext < WEXT_W'(3))
        begin
            width_eff = WEFF_W'(3);
        end
        else if (width_ext > WEXT_W'(MAX_WIDTH))
        begin
            width_eff = WEFF_W'(MAX_WIDTH);
        end
        else
        begin
            width_eff = width_ext[WEFF_W-1:0];
        end
        if (height_ext < HEXT_W'(2))
        begin
            height_eff = ROW_W'(2);
        end
        else if (height_ext > HEXT_W'(MAX_HEIGHT))
        begin
            height_eff = ROW_W'(MAX_HEIGHT);
        end
        else
        begin
            height_eff = height_ext[ROW_W-1:0];
        end
    end

    assign last_col = COL_W'(width_eff - WEFF_W'(1));

    always_comb
    begin
        scan.row_ge1  = row_reg != '0;
        scan.row_ge2  = row_reg > ROW_W'(1);
        scan.col_zero = col_reg == '0;
        scan.col_last = col_reg == last_col;
        scan.row_is_h = row_reg == height_eff;
        // flush ticks and anything in the drain row count as zero pixels
        pix_in = (row_reg < height_eff && !s_tuser[0]) ? s_tdata : '0;

        if (scan.col_last)
        begin
            col_next = '0;
            row_next = scan.row_is_h ? '0 : row_reg + ROW_W'(1);
        end
        else
        begin
            col_next = col_reg + COL_W'(1);
            row_next = row_reg;
        end
    end

    assign s_tready = !s1_valid_reg || win_ready;
    assign s_accept = s_tvalid && s_tready;
    assign s1_ready = win_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else if (restart)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (s_tready)
            begin
                s1_valid_reg <= s_tvalid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_pix_reg  <= pix_in;
            s1_col_reg  <= col_reg;
            s1_scan_reg <= scan;
        end
    end

    // line ram: high byte older row, low byte newer row; each column moves its newer
    // byte up into the older byte and takes the new pixel when the word leaves stage 1
    assign line_we    = s1_valid_reg && s1_ready;
    assign line_wdata = {line_rdata[PIX_W-1:0], s1_pix_reg};

    ceaf_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr (s1_col_reg),
        .wdata (line_wdata),
        .re    (s_accept),
        .raddr (col_reg),
        .rdata (line_rdata)
    );

    ceaf_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (restart),
        .in_valid  (s1_valid_reg),
        .in_ready  (win_ready),
        .in_pix    (s1_pix_reg),
        .in_scan   (s1_scan_reg),
        .older_pix (line_rdata[LINE_W-1:PIX_W]),
        .newer_pix (line_rdata[PIX_W-1:0]),
        .out_valid (win_valid),
        .out_ready (mac_ready),
        .win       (win),
        .emit      (win_emit)
    );

    ceaf_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (win_valid),
        .in_ready  (mac_ready),
        .win       (win),
        .emit      (win_emit),
        .kernel    (kernel_reg),
        .out_valid (mac_valid),
        .out_ready (out_ready),
        .main_res  (mac_main),
        .edge_res  (mac_edge),
        .out_emit  (mac_emit)
    );

    ceaf_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (mac_valid),
        .in_ready (out_ready),
        .main_res (mac_main),
        .edge_res (mac_edge),
        .emit     (mac_emit),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .m_res    (m_res)
    );

    assign m_tdata = m_res.edge_value;
    assign m_tuser = {m_res.frame_end, m_res.saturated};

endmodule
